/* design/pse_pkg.sv */
package pse_pkg;

   localparam int COORD_WIDTH         = 20;
   localparam int COORD_FRAC_DEFAULT  = 4;
   localparam int NORMAL_FRAC_DEFAULT = 14;
   localparam int WEIGHT_WIDTH        = 12;
   localparam int WEIGHT_FRAC         = 4;
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 12'd16;

   // Difference magnitudes are halved until both fit in this many bits.
   localparam int MAG_LIMIT_BITS = 20;
   localparam int ROOT_IN_WIDTH  = 2 * MAG_LIMIT_BITS + 1 + MAG_LIMIT_BITS;
   localparam int SQRT_STEPS     = (ROOT_IN_WIDTH + 1) / 2;

   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STROKE_WEIGHT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STROKE_COLOR  = 1'b1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic                          last_vertex;
      logic                          loop_close;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic                          end_of_run;
      logic                          end_of_shape;
   } rsp_type;

   typedef enum logic [2:0] {
      CRN_A_UP     = 3'd0,
      CRN_A_DN     = 3'd1,
      CRN_B_UP     = 3'd2,
      CRN_B_DN     = 3'd3,
      CRN_FIRST_UP = 3'd4,
      CRN_FIRST_DN = 3'd5
   } corner_sel_type;

   typedef struct packed {
      logic           load_item;
      logic           first_vertex;
      logic           seg_init;
      logic           seg_sel;
      logic           shift;
      logic           sq1;
      logic           sq2;
      logic           norm_zero;
      logic           sqrt_init;
      logic           sqrt_step;
      logic           div_init;
      logic           div_step;
      logic           div_store;
      logic           axis;
      logic           off_x;
      logic           off_y;
      logic           cap_first;
      logic           emit;
      corner_sel_type emit_sel;
      logic           emit_eor;
      logic           emit_eos;
      logic           commit;
   } pse_cmd_type;

   typedef struct packed {
      logic need_shift;
      logic s_zero;
      logic weight_on;
      logic out_free;
      logic in_last;
      logic item_last;
      logic item_loop;
   } pse_status_type;

endpackage

/* design/pse_datapath.sv */
module pse_datapath import pse_pkg::*; #(
   parameter int COORD_FRAC  = COORD_FRAC_DEFAULT,
   parameter int NORMAL_FRAC = NORMAL_FRAC_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  req_type                    req_payload,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  pse_cmd_type                cmd,
   output pse_status_type             status,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output rsp_type                    rsp_payload
);

   localparam int CW       = COORD_WIDTH;
   localparam int MAG_W    = CW + 1;
   localparam int LIM      = MAG_LIMIT_BITS;
   localparam int SQ_W     = 2 * LIM;
   localparam int S_W      = SQ_W + 1;
   localparam int SQRT_W   = ROOT_IN_WIDTH;
   localparam int ROOT_W   = SQRT_STEPS;
   localparam int Q_W      = NORMAL_FRAC + 2;
   localparam int N_W      = NORMAL_FRAC + 1;
   localparam int DIV_W    = ROOT_W + Q_W;
   localparam int NUM_SH   = NORMAL_FRAC + LIM / 2;
   localparam int M_W      = N_W + WEIGHT_WIDTH;
   localparam int OFS      = NORMAL_FRAC + WEIGHT_FRAC - COORD_FRAC;
   localparam int R_W      = M_W + 1 - OFS;
   localparam int OFF_W    = R_W + 1;
   localparam int SUM_W    = ((CW > OFF_W) ? CW : OFF_W) + 1;
   localparam logic [N_W-1:0] ONE = N_W'(1) << NORMAL_FRAC;

   logic signed [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                 cur_last_ff, cur_last_in, cur_loop_ff, cur_loop_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [CW-1:0] seg_ax_ff, seg_ax_in, seg_ay_ff, seg_ay_in;
   logic signed [CW-1:0] seg_bx_ff, seg_bx_in, seg_by_ff, seg_by_in;
   logic [MAG_W-1:0]     ax_ff, ax_in, ay_ff, ay_in;
   logic                 dx_neg_ff, dx_neg_in, dy_pos_ff, dy_pos_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [S_W-1:0]       s_ff, s_in;
   logic [SQRT_W-1:0]    v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [DIV_W-1:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [N_W-1:0]       cx_ff, cx_in, cy_ff, cy_in;
   logic signed [OFF_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic signed [CW-1:0] fu_x_ff, fu_x_in, fu_y_ff, fu_y_in;
   logic signed [CW-1:0] fd_x_ff, fd_x_in, fd_y_ff, fd_y_in;
   logic [WEIGHT_WIDTH-1:0] weight_ff, weight_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;

   logic signed [CW-1:0]  pa_x, pa_y, pb_x, pb_y;
   logic signed [CW:0]    dx, dy;
   logic [LIM-1:0]        ax_lo, ay_lo, a_lo;
   logic [SQRT_W:0]       trial;
   logic [ROOT_W-1:0]     root;
   logic [N_W-1:0]        off_mag;
   logic                  off_neg;
   logic [M_W-1:0]        prod;
   logic [M_W:0]          rnd;
   logic [R_W-1:0]        off_r;
   logic signed [OFF_W-1:0] off_val;
   logic signed [CW-1:0]  a_up_x, a_up_y, a_dn_x, a_dn_y;
   logic signed [CW-1:0]  b_up_x, b_up_y, b_dn_x, b_dn_y;
   logic                  out_free;

   function automatic logic signed [CW-1:0] corner(input logic signed [CW-1:0] p,
                                                   input logic signed [OFF_W-1:0] o,
                                                   input logic sub);
      logic signed [SUM_W-1:0] sum;
      logic signed [CW-1:0]    res;
      sum = sub ? (SUM_W'(p) - SUM_W'(o)) : (SUM_W'(p) + SUM_W'(o));
      if ((&sum[SUM_W-1:CW-1]) || !(|sum[SUM_W-1:CW-1])) begin
         res = sum[CW-1:0];
      end else if (sum[SUM_W-1]) begin
         res = {1'b1, {(CW-1){1'b0}}};
      end else begin
         res = {1'b0, {(CW-1){1'b1}}};
      end
      return res;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ax_lo    = ax_ff[LIM-1:0];
   assign ay_lo    = ay_ff[LIM-1:0];
   assign a_lo     = cmd.axis ? ay_lo : ax_lo;
   assign root     = r_ff[ROOT_W-1:0];
   assign trial    = {1'b0, r_ff} + {1'b0, bit_ff};

   assign pa_x = cmd.seg_sel ? cur_x_ff : prev_x_ff;
   assign pa_y = cmd.seg_sel ? cur_y_ff : prev_y_ff;
   assign pb_x = cmd.seg_sel ? start_x_ff : cur_x_ff;
   assign pb_y = cmd.seg_sel ? start_y_ff : cur_y_ff;
   assign dx   = (CW+1)'(pb_x) - (CW+1)'(pa_x);
   assign dy   = (CW+1)'(pb_y) - (CW+1)'(pa_y);

   // The normal is (-dy, dx): its x part comes from cy, its y part from cx.
   assign off_mag = cmd.off_y ? cx_ff : cy_ff;
   assign off_neg = cmd.off_y ? dx_neg_ff : dy_pos_ff;
   assign prod    = M_W'(off_mag) * M_W'(weight_ff);
   assign rnd     = (M_W+1)'(prod) + ((M_W+1)'(1) << (OFS - 1));
   assign off_r   = R_W'(rnd >> OFS);
   assign off_val = off_neg ? -$signed({1'b0, off_r}) : $signed({1'b0, off_r});

   assign a_up_x = corner(seg_ax_ff, ox_ff, 1'b0);
   assign a_up_y = corner(seg_ay_ff, oy_ff, 1'b0);
   assign a_dn_x = corner(seg_ax_ff, ox_ff, 1'b1);
   assign a_dn_y = corner(seg_ay_ff, oy_ff, 1'b1);
   assign b_up_x = corner(seg_bx_ff, ox_ff, 1'b0);
   assign b_up_y = corner(seg_by_ff, oy_ff, 1'b0);
   assign b_dn_x = corner(seg_bx_ff, ox_ff, 1'b1);
   assign b_dn_y = corner(seg_by_ff, oy_ff, 1'b1);

   always_comb begin
      cur_x_in = cur_x_ff;   cur_y_in = cur_y_ff;
      cur_last_in = cur_last_ff;   cur_loop_in = cur_loop_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      start_x_in = start_x_ff; start_y_in = start_y_ff;
      seg_ax_in = seg_ax_ff; seg_ay_in = seg_ay_ff;
      seg_bx_in = seg_bx_ff; seg_by_in = seg_by_ff;
      ax_in = ax_ff; ay_in = ay_ff;
      dx_neg_in = dx_neg_ff; dy_pos_in = dy_pos_ff;
      sq_in = sq_ff; s_in = s_ff;
      v_in = v_ff; r_in = r_ff; bit_in = bit_ff;
      rem_in = rem_ff; dvs_in = dvs_ff; q_in = q_ff;
      cx_in = cx_ff; cy_in = cy_ff;
      ox_in = ox_ff; oy_in = oy_ff;
      fu_x_in = fu_x_ff; fu_y_in = fu_y_ff; fd_x_in = fd_x_ff; fd_y_in = fd_y_ff;
      weight_in = weight_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Only the weight is stored; a write to the colour index is not kept here.
      if (csr_write_en && csr_index == CSR_STROKE_WEIGHT) begin
         weight_in = csr_data[WEIGHT_WIDTH-1:0];
      end

      if (cmd.load_item) begin
         cur_x_in = req_payload.point_x;
         cur_y_in = req_payload.point_y;
         cur_last_in = req_payload.last_vertex;
         cur_loop_in = req_payload.loop_close;
      end
      if (cmd.first_vertex) begin
         prev_x_in = req_payload.point_x;  prev_y_in = req_payload.point_y;
         start_x_in = req_payload.point_x; start_y_in = req_payload.point_y;
      end
      if (cmd.seg_init) begin
         seg_ax_in = pa_x; seg_ay_in = pa_y; seg_bx_in = pb_x; seg_by_in = pb_y;
         ax_in = dx[CW] ? MAG_W'(-dx) : MAG_W'(dx);
         ay_in = dy[CW] ? MAG_W'(-dy) : MAG_W'(dy);
         dx_neg_in = dx[CW];
         dy_pos_in = !dy[CW] && (dy != '0);
      end
      if (cmd.shift) begin
         ax_in = ax_ff >> 1;
         ay_in = ay_ff >> 1;
      end
      if (cmd.sq1) begin
         sq_in = SQ_W'(ax_lo) * SQ_W'(ax_lo);
      end
      if (cmd.sq2) begin
         s_in = {1'b0, sq_ff} + S_W'(SQ_W'(ay_lo) * SQ_W'(ay_lo));
      end
      if (cmd.sqrt_init) begin
         v_in = {s_ff, LIM'(0)};
         r_in = '0;
         bit_in = SQRT_W'(1) << (2 * (SQRT_STEPS - 1));
      end
      if (cmd.sqrt_step) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[SQRT_W-1:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.div_init) begin
         rem_in = (DIV_W'(a_lo) << NUM_SH) + DIV_W'(root >> 1);
         dvs_in = DIV_W'(root) << (Q_W - 1);
         q_in = '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
         end
         q_in = {q_ff[Q_W-2:0], rem_ff >= dvs_ff};
         dvs_in = dvs_ff >> 1;
      end
      if (cmd.div_store) begin
         if (cmd.axis) begin
            cy_in = (q_ff > Q_W'(ONE)) ? ONE : q_ff[N_W-1:0];
         end else begin
            cx_in = (q_ff > Q_W'(ONE)) ? ONE : q_ff[N_W-1:0];
         end
      end
      if (cmd.norm_zero) begin
         cx_in = '0;
         cy_in = '0;
      end
      if (cmd.off_x) begin
         ox_in = off_val;
      end
      if (cmd.off_y) begin
         oy_in = off_val;
      end
      if (cmd.cap_first) begin
         fu_x_in = a_up_x; fu_y_in = a_up_y;
         fd_x_in = a_dn_x; fd_y_in = a_dn_y;
      end
      if (cmd.commit) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.end_of_run = cmd.emit_eor;
         rsp_payload_in.end_of_shape = cmd.emit_eos;
         case (cmd.emit_sel)
            CRN_A_UP: begin
               rsp_payload_in.out_x = a_up_x; rsp_payload_in.out_y = a_up_y;
            end
            CRN_A_DN: begin
               rsp_payload_in.out_x = a_dn_x; rsp_payload_in.out_y = a_dn_y;
            end
            CRN_B_UP: begin
               rsp_payload_in.out_x = b_up_x; rsp_payload_in.out_y = b_up_y;
            end
            CRN_B_DN: begin
               rsp_payload_in.out_x = b_dn_x; rsp_payload_in.out_y = b_dn_y;
            end
            CRN_FIRST_UP: begin
               rsp_payload_in.out_x = fu_x_ff; rsp_payload_in.out_y = fu_y_ff;
            end
            default: begin
               rsp_payload_in.out_x = fd_x_ff; rsp_payload_in.out_y = fd_y_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         weight_ff <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff <= cur_x_in;     cur_y_ff <= cur_y_in;
      cur_last_ff <= cur_last_in; cur_loop_ff <= cur_loop_in;
      prev_x_ff <= prev_x_in;   prev_y_ff <= prev_y_in;
      start_x_ff <= start_x_in; start_y_ff <= start_y_in;
      seg_ax_ff <= seg_ax_in;   seg_ay_ff <= seg_ay_in;
      seg_bx_ff <= seg_bx_in;   seg_by_ff <= seg_by_in;
      ax_ff <= ax_in;           ay_ff <= ay_in;
      dx_neg_ff <= dx_neg_in;   dy_pos_ff <= dy_pos_in;
      sq_ff <= sq_in;           s_ff <= s_in;
      v_ff <= v_in;             r_ff <= r_in;       bit_ff <= bit_in;
      rem_ff <= rem_in;         dvs_ff <= dvs_in;   q_ff <= q_in;
      cx_ff <= cx_in;           cy_ff <= cy_in;
      ox_ff <= ox_in;           oy_ff <= oy_in;
      fu_x_ff <= fu_x_in;       fu_y_ff <= fu_y_in;
      fd_x_ff <= fd_x_in;       fd_y_ff <= fd_y_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign status.need_shift = (|ax_ff[MAG_W-1:LIM]) || (|ay_ff[MAG_W-1:LIM]);
   assign status.s_zero     = (s_ff == '0);
   assign status.weight_on  = (weight_ff != '0);
   assign status.out_free   = out_free;
   assign status.in_last    = req_payload.last_vertex;
   assign status.item_last  = cur_last_ff;
   assign status.item_loop  = cur_loop_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_eos_is_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.end_of_shape) |-> rsp_payload_ff.end_of_run)
      else $error("end of shape without end of run");
   a_norm_clip: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_store && !cmd.axis) |=> (cx_ff <= ONE))
      else $error("normal component above one");
   a_sum_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.sq2 |=> ((s_ff == '0) == (($past(ax_lo) == '0) && ($past(ay_lo) == '0))))
      else $error("squared length zero flag wrong");
`endif

endmodule

/* design/pse_ctrl.sv */
module pse_ctrl import pse_pkg::*; #(
   parameter int NORMAL_FRAC = NORMAL_FRAC_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  pse_status_type status,
   output pse_cmd_type    cmd
);

   localparam int Q_W     = NORMAL_FRAC + 2;
   localparam int CNT_MAX = (SQRT_STEPS > Q_W) ? SQRT_STEPS : Q_W;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   typedef enum logic [14:0] {
      S_IDLE      = 15'h0001,
      S_SEG       = 15'h0002,
      S_SHIFT     = 15'h0004,
      S_SQ1       = 15'h0008,
      S_SQ2       = 15'h0010,
      S_ROOT_INIT = 15'h0020,
      S_ROOT      = 15'h0040,
      S_DIV_INIT  = 15'h0080,
      S_DIV       = 15'h0100,
      S_DIV_END   = 15'h0200,
      S_OFFX      = 15'h0400,
      S_OFFY      = 15'h0800,
      S_CAP       = 15'h1000,
      S_EMIT      = 15'h2000,
      S_DONE      = 15'h4000
   } state_type;

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           seg_sel_ff, seg_sel_in;
   logic           axis_ff, axis_in;
   corner_sel_type sel_ff, sel_in;
   logic           have_prev_ff, have_prev_in;
   logic           have_seg_ff, have_seg_in;
   logic           closing, final_rsp, advance;

   assign req_stall = (state_ff != S_IDLE);
   assign closing   = status.item_last && status.item_loop;
   assign final_rsp = (sel_ff == CRN_B_DN && !seg_sel_ff && !closing)
                      || (sel_ff == CRN_FIRST_DN);
   // With zero weight the sequence still runs, only nothing is sent.
   assign advance   = !status.weight_on || status.out_free;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      seg_sel_in = seg_sel_ff;
      axis_in = axis_ff;
      sel_in = sel_ff;
      have_prev_in = have_prev_ff;
      have_seg_in = have_seg_ff;
      cmd = '0;
      cmd.seg_sel = seg_sel_ff;
      cmd.axis = axis_ff;
      cmd.emit_sel = sel_ff;
      cmd.emit_eor = final_rsp;
      cmd.emit_eos = final_rsp && status.item_last;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (!have_prev_ff) begin
                  cmd.first_vertex = 1'b1;
                  have_prev_in = !status.in_last;
               end else begin
                  seg_sel_in = 1'b0;
                  state_in = S_SEG;
               end
            end
         end
         S_SEG: begin
            cmd.seg_init = 1'b1;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (status.need_shift) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = S_SQ1;
            end
         end
         S_SQ1: begin
            cmd.sq1 = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.sq2 = 1'b1;
            state_in = S_ROOT_INIT;
         end
         S_ROOT_INIT: begin
            if (status.s_zero) begin
               cmd.norm_zero = 1'b1;
               state_in = S_OFFX;
            end else begin
               cmd.sqrt_init = 1'b1;
               cnt_in = '0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               axis_in = 1'b0;
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            cmd.div_store = 1'b1;
            if (!axis_ff) begin
               axis_in = 1'b1;
               state_in = S_DIV_INIT;
            end else begin
               state_in = S_OFFX;
            end
         end
         S_OFFX: begin
            cmd.off_x = 1'b1;
            state_in = S_OFFY;
         end
         S_OFFY: begin
            cmd.off_y = 1'b1;
            state_in = S_CAP;
         end
         S_CAP: begin
            if (!seg_sel_ff && !have_seg_ff) begin
               cmd.cap_first = 1'b1;
               have_seg_in = 1'b1;
            end
            sel_in = CRN_A_UP;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = status.weight_on && status.out_free;
            if (advance) begin
               case (sel_ff)
                  CRN_A_UP: sel_in = CRN_A_DN;
                  CRN_A_DN: sel_in = CRN_B_UP;
                  CRN_B_UP: sel_in = CRN_B_DN;
                  CRN_B_DN: begin
                     if (seg_sel_ff) begin
                        sel_in = CRN_FIRST_UP;
                     end else if (closing) begin
                        seg_sel_in = 1'b1;
                        state_in = S_SEG;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  CRN_FIRST_UP: sel_in = CRN_FIRST_DN;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            cmd.commit = 1'b1;
            if (status.item_last) begin
               have_prev_in = 1'b0;
               have_seg_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         seg_sel_ff <= 1'b0;
         axis_ff <= 1'b0;
         sel_ff <= CRN_A_UP;
         have_prev_ff <= 1'b0;
         have_seg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         seg_sel_ff <= seg_sel_in;
         axis_ff <= axis_in;
         sel_ff <= sel_in;
         have_prev_ff <= have_prev_in;
         have_seg_ff <= have_seg_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("item sent into a full output register");
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (cnt_ff < CNT_W'(SQRT_STEPS)))
      else $error("square root ran too long");
   a_close_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CAP && seg_sel_ff) |-> have_seg_ff)
      else $error("closing segment without first corners");
`endif

endmodule

/* design/polyline_stroke_expander_unit.sv */
// Polyline stroke expander: each accepted vertex after the first of a shape
// yields four triangle strip vertices, and a closing vertex yields ten. The
// block works on one vertex at a time. Segment setup runs a 31-step bit-serial
// square root and the two shared restoring divisions for the unit normal. It
// then sends one strip vertex per cycle while the result side does not stall.
// A zero-length segment skips the root and the divisions. The next vertex is
// taken while the last strip vertex still waits in the output register.
// Stroke weight zero sends nothing but still tracks the shape.
module polyline_stroke_expander_unit import pse_pkg::*; #(
   parameter int COORD_FRAC  = COORD_FRAC_DEFAULT,
   parameter int NORMAL_FRAC = NORMAL_FRAC_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_payload,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   pse_cmd_type    cmd;
   pse_status_type status;

   pse_ctrl #(
      .NORMAL_FRAC(NORMAL_FRAC)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pse_datapath #(
      .COORD_FRAC (COORD_FRAC),
      .NORMAL_FRAC(NORMAL_FRAC)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule
